@@ hdl/swst_pkg.sv @@
// Shared types and codes for the sliding window slot table.
`timescale 1ns / 1ps

package swst_pkg;

  // Operation codes carried in the request.
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Status codes returned with every result.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BELOW    = 2'd1;
  localparam logic [1:0] STATUS_CAPACITY = 2'd2;

  // One request as it crosses the command port.
  typedef struct packed {
    logic        operation;
    logic [30:0] slot_index;
    logic [31:0] slot_value;
  } slot_req_t;

  // One result as it leaves the block.
  typedef struct packed {
    logic [31:0] read_value;
    logic [1:0]  status;
    logic [12:0] filled_count;
    logic [30:0] window_low;
    logic [31:0] window_high;
  } slot_resp_t;

endpackage

@@ hdl/sliding_window_slot_table.sv @@
// Sliding window slot table: slot store, window control and access sequencer.
`timescale 1ns / 1ps

// Usage.
// A request (read or write of one slot by global index) is taken at a rising
// edge where start is high and busy is low. Writing zero clears a slot. Each
// request produces exactly one result, shown on result for one cycle while
// done is high; the receiver must take it then, as there is no back pressure.
// busy is low again in the cycle that done is high, so a new request may be
// taken at the edge that ends it.
// A read, clear or rejected write that misses the window skips the store
// access. A write beyond the window first grows it in whole CHUNKs until the
// slot is covered. Every CLEAR_PERIOD-th in-window clear runs a leading-slot
// scan through the single memory read port, which examines one slot after
// another and stops at a used slot or when it reaches the cleared slot.
// The store has one read and one write port; every slot access and the scan
// share the read port, as they share the ring address adder.
// After reset the block sweeps the store to zero, one slot per cycle, and
// holds busy high until the sweep is done before it takes the first request.
module sliding_window_slot_table #(
  parameter int CAPACITY     = 4096,
  parameter int CHUNK        = 1024,
  parameter int CLEAR_PERIOD = 16,
  parameter int MIN_LEAD     = 16,
  parameter int VALUE_BITS   = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  swst_pkg::slot_req_t   request,
  output logic                  done,
  output swst_pkg::slot_resp_t  result
);

  import swst_pkg::*;

  localparam int AW    = $clog2(CAPACITY);
  localparam int SW    = $clog2(CAPACITY + 1);
  localparam int TW    = $clog2(CLEAR_PERIOD + 1);
  localparam int SIZE0 = (CHUNK < CAPACITY) ? CHUNK : CAPACITY;
  localparam int MAXW  = (CAPACITY / CHUNK) * CHUNK;

  localparam logic [AW:0]   CAP_W     = (AW + 1)'(CAPACITY);
  localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);
  localparam logic [AW-1:0] LEAD_MIN  = AW'(MIN_LEAD);
  localparam logic [SW-1:0] SIZE_INIT = SW'(SIZE0);
  localparam logic [SW-1:0] CHUNK_W   = SW'(CHUNK);
  localparam logic [30:0]   MAXW_W    = 31'(MAXW);
  localparam logic [TW-1:0] TALLY_TOP = TW'(CLEAR_PERIOD - 1);

  // Sequencer state codes.
  localparam logic [3:0] ST_CLR    = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_CHECK  = 4'd2;
  localparam logic [3:0] ST_RDWAIT = 4'd3;
  localparam logic [3:0] ST_WRWAIT = 4'd4;
  localparam logic [3:0] ST_GROW   = 4'd5;
  localparam logic [3:0] ST_SCADDR = 4'd6;
  localparam logic [3:0] ST_SCCHK  = 4'd7;
  localparam logic [3:0] ST_ADV    = 4'd8;
  localparam logic [3:0] ST_RESP   = 4'd9;

  logic [3:0]            state;
  logic [AW-1:0]         clr_addr;
  slot_req_t             req_q;
  logic [30:0]           offset;
  logic [SW-1:0]         size;
  logic [AW-1:0]         ring_base;
  logic [SW-1:0]         used_count;
  logic [TW-1:0]         clear_tally;
  logic [AW-1:0]         scan_i;
  logic [AW-1:0]         slot_addr;
  logic [VALUE_BITS-1:0] rd_hold;
  logic [1:0]            status;

  logic [VALUE_BITS-1:0] mem [CAPACITY];
  logic [VALUE_BITS-1:0] mem_q;
  logic                  mem_we;
  logic [AW-1:0]         mem_wa;
  logic [VALUE_BITS-1:0] mem_wd;

  logic [AW-1:0]         pos;
  logic [AW:0]           phys_sum;
  logic [AW-1:0]         paddr;
  logic [30:0]           rel;
  logic                  below;
  logic                  in_window;
  logic [63:0]           val_ext;
  logic [VALUE_BITS-1:0] wval;
  logic                  is_clear;
  logic [63:0]           rd_ext;
  logic [31:0]           used_ext;

  // Request decode against the current window.
  assign rel       = req_q.slot_index - offset;
  assign below     = req_q.slot_index < offset;
  assign in_window = !below && (rel < 31'(size));
  assign val_ext   = {32'd0, req_q.slot_value};
  assign wval      = val_ext[VALUE_BITS-1:0];
  assign is_clear  = (wval == '0);

  // Shared ring address unit: window position to physical slot.
  always_comb begin
    unique case (state)
      ST_SCADDR: pos = scan_i;
      ST_ADV:    pos = scan_i - AW'(1);
      default:   pos = rel[AW-1:0];
    endcase
  end

  assign phys_sum = {1'b0, ring_base} + {1'b0, pos};
  assign paddr    = (phys_sum >= CAP_W) ? AW'(phys_sum - CAP_W) : phys_sum[AW-1:0];

  // Store write port: the reset sweep or the slot update of an access.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = slot_addr;
    mem_wd = wval;
    if (state == ST_CLR) begin
      mem_we = 1'b1;
      mem_wa = clr_addr;
      mem_wd = '0;
    end else if (state == ST_WRWAIT) begin
      mem_we = 1'b1;
    end
  end

  // Slot store with a registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q <= mem[paddr];
  end

  // Access sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLR;
      clr_addr    <= '0;
      offset      <= '0;
      size        <= SIZE_INIT;
      ring_base   <= '0;
      used_count  <= '0;
      clear_tally <= '0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_CLR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_SLOT) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            req_q <= request;
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          rd_hold   <= '0;
          status    <= STATUS_OK;
          slot_addr <= paddr;
          if (req_q.operation == OP_READ) begin
            state <= in_window ? ST_RDWAIT : ST_RESP;
          end else if (is_clear) begin
            state <= in_window ? ST_WRWAIT : ST_RESP;
          end else if (below) begin
            status <= STATUS_BELOW;
            state  <= ST_RESP;
          end else if (in_window) begin
            state <= ST_WRWAIT;
          end else if (rel < MAXW_W) begin
            state <= ST_GROW;
          end else begin
            status <= STATUS_CAPACITY;
            state  <= ST_RESP;
          end
        end
        ST_RDWAIT: begin
          rd_hold <= mem_q;
          state   <= ST_RESP;
        end
        ST_GROW: begin
          // Grow by one chunk a cycle until the slot is covered.
          if (31'(size) <= rel) begin
            size <= size + CHUNK_W;
          end else begin
            slot_addr <= paddr;
            state     <= ST_WRWAIT;
          end
        end
        ST_WRWAIT: begin
          if (is_clear) begin
            if (mem_q != '0) begin
              used_count <= used_count - SW'(1);
            end
            if (clear_tally == TALLY_TOP) begin
              clear_tally <= '0;
              scan_i      <= '0;
              state       <= ST_SCADDR;
            end else begin
              clear_tally <= clear_tally + TW'(1);
              state       <= ST_RESP;
            end
          end else begin
            if (mem_q == '0) begin
              used_count <= used_count + SW'(1);
            end
            state <= ST_RESP;
          end
        end
        ST_SCADDR: begin
          // The scan stops at the cleared slot if nothing is found before it.
          state <= (scan_i == rel[AW-1:0]) ? ST_ADV : ST_SCCHK;
        end
        ST_SCCHK: begin
          if (mem_q != '0) begin
            state <= ST_ADV;
          end else begin
            scan_i <= scan_i + AW'(1);
            state  <= ST_SCADDR;
          end
        end
        ST_ADV: begin
          // Skip an empty lead of MIN_LEAD or more, keeping one slot margin.
          if (scan_i >= LEAD_MIN && SW'(scan_i) < size) begin
            ring_base <= paddr;
            offset    <= offset + 31'(scan_i - AW'(1));
          end
          state <= ST_RESP;
        end
        ST_RESP: begin
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Result register, loaded once the state reflects the finished item.
  assign rd_ext   = 64'(rd_hold);
  assign used_ext = 32'(used_count);

  always_ff @(posedge clk) begin
    if (state == ST_RESP) begin
      result.read_value   <= rd_ext[31:0];
      result.status       <= status;
      result.filled_count <= used_ext[12:0];
      result.window_low   <= offset;
      result.window_high  <= {1'b0, offset} + 32'(size);
    end
  end

  assign busy = (state != ST_IDLE);

  // The result strobe only appears once the block is free again.
  a_done_free: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // An accepted transfer always makes the block busy, with no result strobe yet.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted request did not hold the block busy");

  // The window never shrinks below its initial size or exceeds the store.
  a_size_range: assert property (@(posedge clk) disable iff (rst)
    (size >= SIZE_INIT) && (SW'(size) <= SW'(CAPACITY)))
    else $error("window size out of range");

  // The filled count cannot exceed the slots in the window.
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    (state != ST_CLR) |-> (used_count <= size))
    else $error("filled count exceeds window size");

  // The window offset only moves right.
  a_offset_mono: assert property (@(posedge clk) disable iff (rst)
    (state != ST_CLR) |=> (offset >= $past(offset)))
    else $error("window offset moved left");

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for the sliding window slot table.
`timescale 1ns / 1ps

module tb;
  import swst_pkg::*;

  localparam int CAPACITY     = 4096;
  localparam int CHUNK        = 1024;
  localparam int CLEAR_PERIOD = 16;
  localparam int MIN_LEAD     = 16;
  localparam int VALUE_BITS   = 32;
  localparam int RANDOM_ITEMS = 1200;
  localparam int DRAIN_CYCLES = 20;
  localparam int PRINT_LIMIT  = 200;
  // The slowest legal run has the reset sweep, then a leading-slot scan across
  // the window on every sixteenth in-window clear, plus sender gaps.
  // This limit leaves ample margin for that.
  localparam int CYCLE_LIMIT  = 4000000;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic       done;
  slot_req_t  request;
  slot_resp_t result;

  sliding_window_slot_table #(
    .CAPACITY(CAPACITY),
    .CHUNK(CHUNK),
    .CLEAR_PERIOD(CLEAR_PERIOD),
    .MIN_LEAD(MIN_LEAD),
    .VALUE_BITS(VALUE_BITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .done(done),
    .result(result)
  );

  // One row of the directed stimulus; typed rows carry a hand-written result.
  typedef struct {
    slot_req_t  req;
    bit         typed;
    slot_resp_t want;
  } directed_row_t;

  directed_row_t directed_rows[$];
  slot_resp_t    expected_results[$];

  // Shadow copy of the table state.
  bit [31:0]   shadow_slots [CAPACITY];
  int unsigned shadow_offset;
  int unsigned shadow_size;
  int unsigned shadow_base;
  int unsigned shadow_used;
  int unsigned shadow_clears;

  int unsigned errors = 0;
  int unsigned result_count = 0;
  int unsigned cycle_count = 0;

  // Free-running clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Print a mismatch and count it; printing stops after PRINT_LIMIT errors to bound the log.
  task automatic flag_error(input string msg);
    if (errors < PRINT_LIMIT) $display("ERROR: %s", msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      flag_error($sformatf("result %0d %s: got %h, want %h", result_count, name, got, want));
  endtask

  task automatic add_row(input logic op, input int unsigned idx, input logic [31:0] val,
                         input bit typed, input logic [31:0] rd, input logic [1:0] st,
                         input int unsigned filled, input int unsigned lo,
                         input int unsigned hi);
    directed_row_t row;
    row.req.operation     = op;
    row.req.slot_index    = idx[30:0];
    row.req.slot_value    = val;
    row.typed             = typed;
    row.want.read_value   = rd;
    row.want.status       = st;
    row.want.filled_count = filled[12:0];
    row.want.window_low   = lo[30:0];
    row.want.window_high  = hi;
    directed_rows.push_back(row);
  endtask

  // Physical slot of a window position, through the circular base pointer.
  function automatic int unsigned ring_slot(input int unsigned pos);
    return (shadow_base + pos) % CAPACITY;
  endfunction

  // Apply one request to the shadow table and return the result it produces.
  function automatic slot_resp_t predict_slot_result(input slot_req_t r);
    slot_resp_t      resp;
    int unsigned     idx;
    int unsigned     rel;
    int unsigned     phys;
    int unsigned     lead;
    longint unsigned need;
    bit              in_window;
    resp      = '0;
    idx       = 32'(r.slot_index);
    rel       = idx - shadow_offset;
    in_window = (idx >= shadow_offset) && (rel < shadow_size);
    if (r.operation == OP_READ) begin
      if (in_window) resp.read_value = shadow_slots[ring_slot(rel)];
    end else if (r.slot_value == '0) begin
      // A clear only acts inside the window; every such clear counts.
      if (in_window) begin
        phys = ring_slot(rel);
        if (shadow_slots[phys] != '0) shadow_used--;
        shadow_slots[phys] = '0;
        shadow_clears++;
        if (shadow_clears >= CLEAR_PERIOD) begin
          shadow_clears = 0;
          // Find the first used slot ahead of the cleared one.
          lead = 0;
          while (lead < rel && shadow_slots[ring_slot(lead)] == '0) lead++;
          if (lead >= MIN_LEAD && lead < shadow_size) begin
            shadow_base = ring_slot(lead - 1);
            shadow_offset += lead - 1;
          end
        end
      end
    end else if (idx < shadow_offset) begin
      resp.status = STATUS_BELOW;
    end else begin
      // Grow the window in whole chunks when the write lands past its end.
      need = shadow_size;
      if (!in_window) need = (longint'(rel / CHUNK) + 1) * CHUNK;
      if (need > CAPACITY) begin
        resp.status = STATUS_CAPACITY;
      end else begin
        shadow_size = 32'(need);
        phys = ring_slot(rel);
        if (shadow_slots[phys] == '0) shadow_used++;
        shadow_slots[phys] = r.slot_value;
      end
    end
    resp.filled_count = shadow_used[12:0];
    resp.window_low   = shadow_offset[30:0];
    resp.window_high  = shadow_offset + shadow_size;
    return resp;
  endfunction

  // Random request aimed at the live window: a working zone at the low end
  // where clears sweep the leading slots so that the window keeps advancing,
  // plus the whole window, growth, the region below, the capacity edge and noise.
  function automatic slot_req_t random_request();
    slot_req_t   r;
    int unsigned pick;
    int unsigned idx;
    int unsigned span;
    r.operation  = 1'($urandom_range(0, 1));
    r.slot_value = $urandom;
    if (r.operation == OP_WRITE) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: r.slot_value = '0;
        4:          r.slot_value = '1;
        5:          r.slot_value = 32'd1;
        default:    ;
      endcase
    end
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      if (r.operation == OP_WRITE && r.slot_value != '0)
        idx = shadow_offset + $urandom_range(24, 95);
      else
        idx = shadow_offset + $urandom_range(0, 47);
    end else if (pick < 58) begin
      idx = shadow_offset + $urandom_range(0, shadow_size - 1);
    end else if (pick < 70) begin
      idx = shadow_offset + shadow_size + $urandom_range(0, 1100);
    end else if (pick < 82) begin
      span = (shadow_offset < 200) ? shadow_offset : 200;
      idx  = shadow_offset - $urandom_range(0, span);
    end else if (pick < 90) begin
      idx = shadow_offset + $urandom_range(CAPACITY - 8, CAPACITY + 7);
    end else begin
      idx = $urandom;
    end
    r.slot_index = idx[30:0];
    return r;
  endfunction

  // Offer one request after a random gap, wait for the transfer, then predict.
  task automatic send_request(input slot_req_t r, input bit typed, input slot_resp_t want,
                              input int unsigned idle_pct);
    slot_resp_t predicted;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    request <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = predict_slot_result(r);
    expected_results.push_back(typed ? want : predicted);
  endtask

  // Compare every result transfer with the oldest expectation.
  always @(posedge clk) begin
    slot_resp_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        flag_error($sformatf("result %0d arrived with nothing expected", result_count));
      end else begin
        want = expected_results.pop_front();
        check_field("read_value", result.read_value, want.read_value);
        check_field("status", 32'(result.status), 32'(want.status));
        check_field("filled_count", 32'(result.filled_count), 32'(want.filled_count));
        check_field("window_low", 32'(result.window_low), 32'(want.window_low));
        check_field("window_high", result.window_high, want.window_high);
      end
      result_count++;
    end
  end

  // Watchdog against a hung block.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    slot_resp_t  no_want;
    int unsigned total;
    int unsigned idle_pct;
    clk           = 1'b0;
    rst           = 1'b1;
    start         = 1'b0;
    request       = '0;
    no_want       = '0;
    shadow_offset = 0;
    shadow_size   = CHUNK;
    shadow_base   = 0;
    shadow_used   = 0;
    shadow_clears = 0;

    // Directed part: empty read after reset, capacity limits, growth, overwrite.
    add_row(OP_READ,  0,           32'h0,        1'b1, 32'h0, STATUS_OK, 0, 0, 1024);
    add_row(OP_WRITE, 32'h7FFFFFFF, 32'h1,       1'b1, 32'h0, STATUS_CAPACITY, 0, 0, 1024);
    add_row(OP_WRITE, 1500,        32'hFFFFFFFF, 1'b1, 32'h0, STATUS_OK, 1, 0, 2048);
    add_row(OP_WRITE, 4096,        32'h12345678, 1'b1, 32'h0, STATUS_CAPACITY, 1, 0, 2048);
    add_row(OP_READ,  1500,        32'h0,        1'b1, 32'hFFFFFFFF, STATUS_OK, 1, 0, 2048);
    add_row(OP_READ,  32'h7FFFFFFF, 32'hFFFFFFFF, 1'b1, 32'h0, STATUS_OK, 1, 0, 2048);
    add_row(OP_WRITE, 1500,        32'hA5A5A5A5, 1'b0, 0, STATUS_OK, 0, 0, 0);
    add_row(OP_WRITE, 40,          32'h5A5A5A5A, 1'b0, 0, STATUS_OK, 0, 0, 0);
    // A clear above the window is ignored and does not count.
    add_row(OP_WRITE, 9000,        32'h0,        1'b0, 0, STATUS_OK, 0, 0, 0);
    // Sixteen clears of an empty slot: the scan finds nothing and the window advances.
    for (int k = 0; k < CLEAR_PERIOD; k++)
      add_row(OP_WRITE, 30, 32'h0, 1'b0, 0, STATUS_OK, 0, 0, 0);
    // Below the advanced window: rejected write, empty read, ignored clear.
    add_row(OP_WRITE, 3,           32'h1,        1'b0, 0, STATUS_OK, 0, 0, 0);
    add_row(OP_READ,  5,           32'h0,        1'b0, 0, STATUS_OK, 0, 0, 0);
    add_row(OP_WRITE, 0,           32'h0,        1'b0, 0, STATUS_OK, 0, 0, 0);

    total = directed_rows.size() + RANDOM_ITEMS;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Sender pacing: light gaps, then heavy gaps, then back to back.
    for (int n = 0; n < total; n++) begin
      if (n < total / 3)          idle_pct = 28;
      else if (n < 2 * total / 3) idle_pct = 72;
      else                        idle_pct = 0;
      if (n < directed_rows.size())
        send_request(directed_rows[n].req, directed_rows[n].typed, directed_rows[n].want,
                     idle_pct);
      else
        send_request(random_request(), 1'b0, no_want, idle_pct);
    end
    start <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
